### hdl/nscr_pkg.sv
// Shared constants, types and helper functions for the NMEA sentence checksum receiver.
`default_nettype none

package nscr_pkg;

  localparam int LEN_W      = 11;
  localparam int NUM_TYPES  = 5;
  localparam int PREFIX_LEN = 6;
  localparam int PFX_IDX_W  = $clog2(PREFIX_LEN);
  localparam int TYPE_W     = 3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [LEN_W-1:0] LIMIT_MIN   = 11'd2;
  localparam logic [LEN_W-1:0] LIMIT_MAX   = 11'd1024;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 11'd128;
  // sentence must be longer than this to pass
  localparam logic [LEN_W-1:0] OK_MIN_LEN  = 11'd6;

  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 3'd0;

  // talker/type prefixes: GGA, RMC, GSV, GSA, VTG (codes 1..5 in this order)
  localparam logic [NUM_TYPES-1:0][PREFIX_LEN-1:0][7:0] TYPE_NAMES = '{
    '{8'h47, 8'h54, 8'h56, 8'h50, 8'h47, 8'h24},   // $GPVTG (index reversed)
    '{8'h41, 8'h53, 8'h47, 8'h50, 8'h47, 8'h24},   // $GPGSA
    '{8'h56, 8'h53, 8'h47, 8'h50, 8'h47, 8'h24},   // $GPGSV
    '{8'h43, 8'h4D, 8'h52, 8'h50, 8'h47, 8'h24},   // $GPRMC
    '{8'h41, 8'h47, 8'h47, 8'h50, 8'h47, 8'h24}    // $GPGGA
  };

  typedef struct packed {
    logic              sentence_ok;
    logic              end_cause;
    logic [TYPE_W-1:0] sentence_type;
    logic [7:0]        computed_sum;
    logic [7:0]        received_sum;
    logic [LEN_W-1:0]  sentence_length;
  } nscr_result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } nscr_item_t;

  typedef struct packed {
    logic is_hex;
    logic [3:0] nibble;
  } nscr_hex_t;

  function automatic nscr_hex_t hex_of(input logic [7:0] b);
    nscr_hex_t h;
    h = '0;
    if (b inside {[8'h30:8'h39]}) begin
      h.is_hex = 1'b1;
      h.nibble = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.is_hex = 1'b1;
      h.nibble = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.is_hex = 1'b1;
      h.nibble = 4'(b - 8'h37);
    end
    return h;
  endfunction

  // clamp the written limit and return limit minus one
  function automatic logic [LEN_W-1:0] limit_m1(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] l;
    if (v < LIMIT_MIN) l = LIMIT_MIN;
    else if (v > LIMIT_MAX) l = LIMIT_MAX;
    else l = v;
    return l - 11'd1;
  endfunction

endpackage

`default_nettype wire

### hdl/nscr_ifs.sv
// Channel interfaces: received byte, result and limit configuration.
`default_nettype none

interface nscr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nscr_result_if import nscr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              sentence_ok;
  logic              end_cause;
  logic [TYPE_W-1:0] sentence_type;
  logic [7:0]        computed_sum;
  logic [7:0]        received_sum;
  logic [LEN_W-1:0]  sentence_length;
  modport source (output valid, output sentence_ok, output end_cause, output sentence_type,
                  output computed_sum, output received_sum, output sentence_length,
                  input ready);
  modport sink   (input valid, input sentence_ok, input end_cause, input sentence_type,
                  input computed_sum, input received_sum, input sentence_length,
                  output ready);
endinterface

interface nscr_cfg_if import nscr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] len_limit;
  modport source (output valid, output len_limit, input ready);
  modport sink   (input valid, input len_limit, output ready);
endinterface

`default_nettype wire

### hdl/nscr_in_reg.sv
// Input register: holds one received byte until the sentence tracker takes it.
`default_nettype none

module nscr_in_reg import nscr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nscr_byte_if.sink  in_if,
  input  wire logic  take,
  output nscr_item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_if.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_if.ready) valid_nxt = in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) byte_r <= in_if.rx_byte;
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

`default_nettype wire

### hdl/nscr_tracker.sv
// Sentence tracker: per-byte state update, checksum, hex decode and type match.
`default_nettype none

module nscr_tracker import nscr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  nscr_cfg_if.sink        cfg_if,
  input  wire nscr_item_t item,
  input  wire logic       take,
  output logic            res_valid,
  output nscr_result_t    res
);

  logic                 in_sent_r, in_sent_nxt;
  logic [LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [7:0]           xor_r, xor_nxt;
  logic                 star_r, star_nxt;
  logic                 ended_r, ended_nxt;
  logic [7:0]           hex_r, hex_nxt;
  logic [1:0]           hexd_r, hexd_nxt;
  logic                 hexstop_r, hexstop_nxt;
  logic [NUM_TYPES-1:0] match_r, match_nxt;
  logic [LEN_W-1:0]     lim_m1_r;

  logic [7:0]  b;
  nscr_hex_t   h;
  logic        is_lf;
  logic        fire;

  assign cfg_if.ready = 1'b1;
  assign b     = item.rx_byte;
  assign h     = hex_of(b);
  assign is_lf = (b == CH_LF);

  always_comb begin
    in_sent_nxt = in_sent_r;
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    star_nxt    = star_r;
    ended_nxt   = ended_r;
    hex_nxt     = hex_r;
    hexd_nxt    = hexd_r;
    hexstop_nxt = hexstop_r;
    match_nxt   = match_r;
    fire        = 1'b0;
    if (take) begin
      if (!in_sent_r) begin
        if (b == CH_DOLLAR) begin
          in_sent_nxt = 1'b1;
          cnt_nxt     = 11'd1;
          xor_nxt     = '0;
          star_nxt    = 1'b0;
          ended_nxt   = 1'b0;
          hex_nxt     = '0;
          hexd_nxt    = '0;
          hexstop_nxt = 1'b0;
          match_nxt   = '1;
        end
      end else begin
        cnt_nxt = cnt_r + 11'd1;
        if (cnt_r < LEN_W'(PREFIX_LEN)) begin
          for (int t = 0; t < NUM_TYPES; t++) begin
            if (TYPE_NAMES[t][cnt_r[PFX_IDX_W-1:0]] != b) match_nxt[t] = 1'b0;
          end
        end
        if (star_r) begin
          if (!hexstop_r) begin
            if (!h.is_hex) begin
              hexstop_nxt = 1'b1;
            end else begin
              hex_nxt  = {hex_r[3:0], h.nibble};
              hexd_nxt = hexd_r + 2'd1;
              if (hexd_r != 2'd0) hexstop_nxt = 1'b1;
            end
          end
        end else if (!ended_r) begin
          if (b == CH_NUL) ended_nxt = 1'b1;
          else if (b == CH_STAR) star_nxt = 1'b1;
          else xor_nxt = xor_r ^ b;
        end
        fire = is_lf || (cnt_nxt >= lim_m1_r);
        if (fire) in_sent_nxt = 1'b0;
      end
    end
  end

  // result fields from the updated state
  always_comb begin
    res = '0;
    res.sentence_ok     = is_lf && (cnt_nxt > OK_MIN_LEN) && star_nxt && (xor_nxt == hex_nxt);
    res.end_cause       = !is_lf;
    res.sentence_type   = TYPE_UNKNOWN;
    if (cnt_nxt >= LEN_W'(PREFIX_LEN)) begin
      // lowest matching type wins
      for (int t = NUM_TYPES - 1; t >= 0; t--) begin
        if (match_nxt[t]) res.sentence_type = TYPE_W'(t + 1);
      end
    end
    res.computed_sum    = xor_nxt;
    res.received_sum    = star_nxt ? hex_nxt : 8'd0;
    res.sentence_length = cnt_nxt;
  end

  assign res_valid = fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0;
      cnt_r     <= '0;
      xor_r     <= '0;
      star_r    <= 1'b0;
      ended_r   <= 1'b0;
      hex_r     <= '0;
      hexd_r    <= '0;
      hexstop_r <= 1'b0;
      match_r   <= '0;
      lim_m1_r  <= limit_m1(LIMIT_RESET);
    end else begin
      in_sent_r <= in_sent_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
      star_r    <= star_nxt;
      ended_r   <= ended_nxt;
      hex_r     <= hex_nxt;
      hexd_r    <= hexd_nxt;
      hexstop_r <= hexstop_nxt;
      match_r   <= match_nxt;
      if (cfg_if.valid && cfg_if.ready) lim_m1_r <= limit_m1(cfg_if.len_limit);
    end
  end

endmodule

`default_nettype wire

### hdl/nscr_out_reg.sv
// Result register: holds one finished sentence result until the sink takes it.
`default_nettype none

module nscr_out_reg import nscr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire nscr_result_t res,
  output logic              free,
  nscr_result_if.source     out_if
);

  logic         valid_r, valid_nxt;
  nscr_result_t res_r;

  assign free = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_if.ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_if.valid           = valid_r;
  assign out_if.sentence_ok     = res_r.sentence_ok;
  assign out_if.end_cause       = res_r.end_cause;
  assign out_if.sentence_type   = res_r.sentence_type;
  assign out_if.computed_sum    = res_r.computed_sum;
  assign out_if.received_sum    = res_r.received_sum;
  assign out_if.sentence_length = res_r.sentence_length;

endmodule

`default_nettype wire

### hdl/nmea_sentence_checksum_receiver.sv
// Top level of the NMEA sentence checksum receiver.
// Takes one received byte per cycle, hunts for '$', then tracks the XOR checksum, the
// hex sum after '*', the length and the sentence type, and gives one result per
// sentence on line feed or when the length reaches the configured limit minus one.
// Each byte passes an input register and the tracker logic into the result register, so
// a result is in the result register once its final byte has left the input register,
// and can then be taken by the sink; a new byte is taken every cycle unless a pending
// result is held up by the sink. The limit (reset 128, clamped to 2..1024) is to be
// written through the cfg channel only while idle; the block does not enforce this.
`default_nettype none

module nmea_sentence_checksum_receiver import nscr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  nscr_byte_if.sink     in_if,
  nscr_result_if.source out_if,
  nscr_cfg_if.sink      cfg_if
);

  nscr_item_t   item;
  nscr_result_t res;
  logic         res_valid;
  logic         out_free;
  logic         take;

  assign take = item.valid && out_free;

  nscr_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .take  (take),
    .item  (item)
  );

  nscr_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_if    (cfg_if),
    .item      (item),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  nscr_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_valid),
    .res    (res),
    .free   (out_free),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

### sim/nmea_sentence_checksum_receiver_test.sv
// Self-checking testbench for the NMEA sentence checksum receiver: random byte streams, scored.
module nmea_sentence_checksum_receiver_test;
  import nscr_pkg::*;

  localparam int          RX_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned RANDOM_ITEMS   = 120;
  localparam logic [7:0]  CH_CR          = 8'h0D;

  // five sentence tags, GGA at index 0 up to VTG at index 4
  localparam logic [NUM_TYPES-1:0][PREFIX_LEN*8-1:0] SENTENCE_TAGS =
    {"$GPVTG", "$GPGSA", "$GPGSV", "$GPRMC", "$GPGGA"};

  typedef enum int {
    GOOD_SUM, BAD_SUM, ONE_DIGIT, NO_STAR, NUL_BEFORE_STAR, NO_DIGIT, THREE_DIGITS,
    NO_LINE_FEED
  } sentence_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  nscr_byte_if   in_if ();
  nscr_result_if out_if ();
  nscr_cfg_if    cfg_if ();

  nmea_sentence_checksum_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #2 clk = ~clk;

  logic [7:0]   pending_bytes [$];
  nscr_result_t expected_sentences [$];
  int unsigned  items_queued = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           in_fire, out_fire, cfg_fire;
  bit           idle_on = 1'b1;
  bit           rx_hold_req = 1'b0;
  bit           rx_holding = 1'b0;

  // sentence tracker state
  logic             in_msg = 1'b0;
  logic [LEN_W-1:0] msg_len = '0;
  logic [7:0]       msg_xor = '0;
  logic             star_hit = 1'b0;
  logic             nul_hit = 1'b0;
  logic [7:0]       rx_sum = '0;
  logic [1:0]       rx_digits = '0;
  logic             rx_sum_done = 1'b0;
  logic [4:0]       type_cand = '0;
  logic [LEN_W-1:0] sentence_cap = LIMIT_RESET - 11'd1;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  task automatic track_sentence_byte(input logic [7:0] b);
    int           pos, t;
    logic [4:0]   dig;
    nscr_result_t r;
    if (!in_msg) begin
      if (b == CH_DOLLAR) begin
        in_msg = 1'b1;
        msg_len = 11'd1;
        msg_xor = '0;
        star_hit = 1'b0;
        nul_hit = 1'b0;
        rx_sum = '0;
        rx_digits = '0;
        rx_sum_done = 1'b0;
        type_cand = '1;
      end
    end else begin
      pos = int'(msg_len);
      msg_len = msg_len + 11'd1;
      if (pos < PREFIX_LEN)
        for (t = 0; t < NUM_TYPES; t++)
          if (SENTENCE_TAGS[t][(PREFIX_LEN-1-pos)*8 +: 8] != b) type_cand[t] = 1'b0;
      if (star_hit) begin
        if (!rx_sum_done) begin
          dig = hex_digit_value(b);
          if (!dig[4]) rx_sum_done = 1'b1;
          else begin
            rx_sum = {rx_sum[3:0], dig[3:0]};
            rx_digits = rx_digits + 2'd1;
            if (rx_digits == 2'd2) rx_sum_done = 1'b1;
          end
        end
      end else if (!nul_hit) begin
        if (b == CH_NUL) nul_hit = 1'b1;
        else if (b == CH_STAR) star_hit = 1'b1;
        else msg_xor = msg_xor ^ b;
      end
      if (b == CH_LF || msg_len >= sentence_cap) begin
        r.sentence_type = TYPE_UNKNOWN;
        if (msg_len >= PREFIX_LEN)
          for (t = NUM_TYPES - 1; t >= 0; t--)
            if (type_cand[t]) r.sentence_type = TYPE_W'(t + 1);
        r.sentence_ok = (b == CH_LF) && (msg_len > OK_MIN_LEN) && star_hit && (msg_xor == rx_sum);
        r.end_cause = (b != CH_LF);
        r.computed_sum = msg_xor;
        r.received_sum = star_hit ? rx_sum : 8'd0;
        r.sentence_length = msg_len;
        expected_sentences.push_back(r);
        in_msg = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string field, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_sentence_result();
    nscr_result_t want;
    if (expected_sentences.size() == 0) begin
      $display("%0t: result with none expected, length %0d", $time, out_if.sentence_length);
      mismatches++;
    end else begin
      want = expected_sentences.pop_front();
      check_field("sentence_ok", want.sentence_ok, out_if.sentence_ok);
      check_field("end_cause", want.end_cause, out_if.end_cause);
      check_field("sentence_type", want.sentence_type, out_if.sentence_type);
      check_field("computed_sum", want.computed_sum, out_if.computed_sum);
      check_field("received_sum", want.received_sum, out_if.received_sum);
      check_field("sentence_length", want.sentence_length, out_if.sentence_length);
    end
  endtask

  // monitor: everything sampled at the rising edge
  always @(posedge clk) begin
    in_fire  = rst_n && in_if.valid && in_if.ready;
    out_fire = rst_n && out_if.valid && out_if.ready;
    cfg_fire = rst_n && cfg_if.valid && cfg_if.ready;
    if (cfg_fire) begin
      if (cfg_if.len_limit < LIMIT_MIN) sentence_cap = LIMIT_MIN - 11'd1;
      else if (cfg_if.len_limit > LIMIT_MAX) sentence_cap = LIMIT_MAX - 11'd1;
      else sentence_cap = cfg_if.len_limit - 11'd1;
    end
    if (in_fire) track_sentence_byte(in_if.rx_byte);
    if (out_fire) check_sentence_result();
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) in_if.valid <= 1'b0;
    else if (!in_if.valid || in_fire) begin
      if (pending_bytes.size() != 0 && !(idle_on && $urandom_range(0, 99) < 26)) begin
        in_if.rx_byte <= pending_bytes.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    out_if.ready <= rst_n && !rx_holding && !(idle_on && $urandom_range(0, 99) < 26);

  // long receiver hold-off, started once by the stimulus
  initial begin
    wait (rx_hold_req);
    rx_holding = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_holding = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    items_queued++;
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return 8'h30 + nib;
    return (lower ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    if (c == CH_STAR) c = ",";
    return c;
  endfunction

  task automatic queue_hex_pair(input logic [7:0] v, input bit lower);
    queue_byte(hex_char(v[7:4], lower));
    queue_byte(hex_char(v[3:0], lower));
  endtask

  // '$', tag, text body, then a checksum tail shaped by a random kind
  task automatic queue_nmea(input int unsigned body_max);
    logic [7:0]     sum, c;
    int unsigned    tag, k, r;
    bit             lower;
    sentence_kind_t kind;
    sum = '0;
    lower = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 14);
    kind = (r < 8) ? GOOD_SUM : sentence_kind_t'(r - 7);
    tag = $urandom_range(0, 6);
    queue_byte(CH_DOLLAR);
    for (k = 0; k < PREFIX_LEN - 1; k++) begin
      if (tag < NUM_TYPES) c = SENTENCE_TAGS[tag][(PREFIX_LEN-2-k)*8 +: 8];
      else c = 8'(8'h41 + $urandom_range(0, 25));
      queue_byte(c);
      sum = sum ^ c;
    end
    repeat ($urandom_range(0, body_max)) begin
      c = random_text_byte();
      queue_byte(c);
      sum = sum ^ c;
    end
    case (kind)
      GOOD_SUM, NO_LINE_FEED: begin
        queue_byte(CH_STAR);
        queue_hex_pair(sum, lower);
      end
      BAD_SUM: begin
        queue_byte(CH_STAR);
        queue_hex_pair(sum ^ (8'd1 << $urandom_range(0, 7)), lower);
      end
      ONE_DIGIT: begin
        queue_byte(CH_STAR);
        queue_byte(hex_char(sum[3:0], lower));
        queue_byte(",");
      end
      NUL_BEFORE_STAR: begin
        queue_byte(CH_NUL);
        queue_byte(CH_STAR);
        queue_hex_pair(sum, lower);
      end
      NO_DIGIT: begin
        queue_byte(CH_STAR);
        queue_byte(lower ? "g" : ",");
      end
      THREE_DIGITS: begin
        queue_byte(CH_STAR);
        queue_hex_pair(sum, lower);
        queue_byte(hex_char(4'($urandom_range(0, 15)), lower));
      end
      default: ;
    endcase
    if (kind != NO_LINE_FEED) begin
      if ($urandom_range(0, 1)) queue_byte(CH_CR);
      queue_byte(CH_LF);
    end
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg_if.len_limit <= v;
    cfg_if.valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_if.valid <= 1'b0;
  endtask

  // closing line feed puts the block back to hunting, then wait for every result
  task automatic finish_phase();
    queue_byte(CH_LF);
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_if.valid || expected_sentences.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned start_count, r;
    logic [LEN_W-1:0] lim;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.len_limit = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limit: noise while hunting, good GGA, '$' inside, zero byte before '*'
    queue_byte(8'hFF);
    queue_byte(CH_NUL);
    queue_byte(CH_LF);
    queue_text("$GPGGA*56\n");
    queue_text("$$x*5c\n");
    queue_byte(CH_DOLLAR);
    queue_byte(CH_NUL);
    queue_text("*1\n");
    finish_phase();

    // smallest limit, and below it; line feed exactly at the limit
    write_limit(11'd2);
    queue_text("$A$\n");
    repeat (2) queue_nmea(4);
    finish_phase();
    write_limit(11'd0);
    queue_text("$A$\n");
    repeat (2) queue_nmea(4);
    finish_phase();

    write_limit(11'd8);
    queue_text("$GPGSV\n$GPR\n");
    repeat (3) queue_nmea(6);
    finish_phase();

    // above the top limit: one sentence that runs to the clamped length, no idling
    idle_on = 1'b0;
    write_limit(11'd2047);
    queue_byte(CH_DOLLAR);
    repeat (1030) queue_byte(8'(8'h41 + $urandom_range(0, 25)));
    finish_phase();
    idle_on = 1'b1;

    write_limit(11'd1024);
    queue_nmea(40);
    finish_phase();

    // receiver holds off while bytes keep coming
    write_limit(11'd12);
    repeat (8) queue_nmea(8);
    rx_hold_req = 1'b1;
    finish_phase();

    start_count = items_queued;
    while (items_queued - start_count < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) lim = LEN_W'($urandom_range(0, 1));
      else if (r < 6) lim = LEN_W'($urandom_range(2, 24));
      else if (r < 8) lim = LEN_W'($urandom_range(25, 128));
      else if (r == 8) lim = LEN_W'($urandom_range(129, 1024));
      else lim = LEN_W'($urandom_range(1025, 2047));
      write_limit(lim);
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 3) == 0) queue_noise();
        else queue_nmea($urandom_range(0, 3) == 0 ? 30 : 10);
      end
      finish_phase();
    end

    if (mismatches == 0 && expected_sentences.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
